### hdl/lcps_pkg.sv
// Shared types, constants and helpers for the little-core placement selector.
package lcps_pkg;

  // Table and field sizing
  localparam int NUM_CORES   = 8;
  localparam int MASK_W      = 8;
  localparam int CORE_IDX_W  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int SCAN_CORES  = (NUM_CORES < MASK_W) ? NUM_CORES : MASK_W;
  localparam int SCAN_IDX_W  = (SCAN_CORES > 1) ? $clog2(SCAN_CORES) : 1;
  localparam int CPU_INDEX_W = 3;
  localparam int UTIL_W      = 11;
  localparam int FREQ_W      = 22;
  localparam int CLUSTER_W   = 4;
  localparam int PCT_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 22;
  localparam int PROD_W      = 18;

  // Arithmetic constants
  localparam logic [UTIL_W-1:0] UTIL_MAX      = 11'd1024;
  localparam logic [PCT_W-1:0]  LIGHT_CAP_PCT = 7'd80;
  localparam logic [PCT_W-1:0]  PERCENT_SCALE = 7'd100;

  // Register reset values
  localparam logic [PCT_W-1:0]  HEAVY_PCT_RST = 7'd50;
  localparam logic [PCT_W-1:0]  BUSY_PCT_RST  = 7'd85;
  localparam logic [FREQ_W-1:0] TRIG_FREQ_RST = 22'd1503000;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAVY_PCT = 2'd0,
    CFG_BUSY_PCT  = 2'd1,
    CFG_TRIG_FREQ = 2'd2
  } cfg_idx_t;

  // Request kinds
  typedef enum logic {
    ACT_UPDATE = 1'b0,
    ACT_PLACE  = 1'b1
  } action_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic write_entry;
    logic load_task;
    logic fetch;
    logic eval;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic fetch_last;
  } dp_status_t;

  // Clamp a utilisation or capacity value to the maximum of 1024.
  function automatic logic [UTIL_W-1:0] sat_util(input logic [UTIL_W-1:0] v);
    return (v > UTIL_MAX) ? UTIL_MAX : v;
  endfunction

endpackage

### hdl/lcps_ctrl.sv
// Controller state machine that sequences table updates and placement scans.
module lcps_ctrl import lcps_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       in_action,
  input  dp_status_t status,
  output logic       busy,
  output dp_cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = start && (state_r == ST_IDLE);

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (action_t'(in_action) == ACT_PLACE)) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (status.fetch_last) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: state_nxt = ST_EMIT;
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy            = 1'b0;
        cmd.write_entry = accept && (action_t'(in_action) == ACT_UPDATE);
        cmd.load_task   = accept && (action_t'(in_action) == ACT_PLACE);
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        cmd.eval  = 1'b1;
      end
      ST_EVAL: cmd.eval = 1'b1;
      ST_EMIT: cmd.emit = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

### hdl/lcps_dp.sv
// Datapath: core table, configuration registers, scan pipeline and result register.
module lcps_dp import lcps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [CPU_INDEX_W-1:0] in_cpu_index,
  input  logic [UTIL_W-1:0]      in_cpu_util,
  input  logic [UTIL_W-1:0]      in_cpu_capacity,
  input  logic [FREQ_W-1:0]      in_cpu_freq_khz,
  input  logic [CLUSTER_W-1:0]   in_cpu_cluster,
  input  logic [UTIL_W-1:0]      in_task_util,
  input  logic [UTIL_W-1:0]      in_task_capacity,
  input  logic [MASK_W-1:0]      in_allowed_mask,
  output logic                   out_valid,
  output logic                   out_found,
  output logic [CPU_INDEX_W-1:0] out_chosen_cpu,
  output logic                   out_task_light
);

  // Configuration registers
  logic [PCT_W-1:0]  heavy_pct_r;
  logic [PCT_W-1:0]  busy_pct_r;
  logic [FREQ_W-1:0] trig_freq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heavy_pct_r <= HEAVY_PCT_RST;
      busy_pct_r  <= BUSY_PCT_RST;
      trig_freq_r <= TRIG_FREQ_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_HEAVY_PCT: heavy_pct_r <= cfg_data[PCT_W-1:0];
        CFG_BUSY_PCT:  busy_pct_r  <= cfg_data[PCT_W-1:0];
        CFG_TRIG_FREQ: trig_freq_r <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Core table, cleared at reset and written by update requests
  logic [UTIL_W-1:0]    core_util_r    [NUM_CORES];
  logic [UTIL_W-1:0]    core_cap_r     [NUM_CORES];
  logic [FREQ_W-1:0]    core_freq_r    [NUM_CORES];
  logic [CLUSTER_W-1:0] core_cluster_r [NUM_CORES];
  logic                 idx_in_range;

  assign idx_in_range = (32'(in_cpu_index) < NUM_CORES);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CORES; i++) begin
        core_util_r[i]    <= '0;
        core_cap_r[i]     <= '0;
        core_freq_r[i]    <= '0;
        core_cluster_r[i] <= '0;
      end
    end else if (cmd.write_entry && idx_in_range) begin
      core_util_r[CORE_IDX_W'(in_cpu_index)]    <= sat_util(in_cpu_util);
      core_cap_r[CORE_IDX_W'(in_cpu_index)]     <= sat_util(in_cpu_capacity);
      core_freq_r[CORE_IDX_W'(in_cpu_index)]    <= in_cpu_freq_khz;
      core_cluster_r[CORE_IDX_W'(in_cpu_index)] <= in_cpu_cluster;
    end
  end

  // Task capture for a placement request
  logic [UTIL_W-1:0] tutil_r;
  logic [UTIL_W-1:0] tcap_r;
  logic [MASK_W-1:0] mask_r;

  always_ff @(posedge clk) begin
    if (cmd.load_task) begin
      tutil_r <= sat_util(in_task_util);
      tcap_r  <= sat_util(in_task_capacity);
      mask_r  <= in_allowed_mask;
    end
  end

  // Scan counter over the table entries
  logic [SCAN_IDX_W-1:0] scan_idx_r;

  assign status.fetch_last = (32'(scan_idx_r) == SCAN_CORES - 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else if (cmd.load_task) begin
      scan_idx_r <= '0;
    end else if (cmd.fetch && !status.fetch_last) begin
      scan_idx_r <= scan_idx_r + 1'b1;
    end
  end

  // Fetch stage: read one entry, check the cheap conditions and form both products
  logic [CORE_IDX_W-1:0] rd_idx;
  logic                  st_valid_r;
  logic                  st_ok_r;
  logic [PROD_W-1:0]     st_cap_r;
  logic [PROD_W-1:0]     st_util_x_r;
  logic [UTIL_W-1:0]     st_util_r;
  logic [SCAN_IDX_W-1:0] st_idx_r;

  assign rd_idx = CORE_IDX_W'(scan_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= cmd.fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      st_ok_r     <= mask_r[scan_idx_r] && (core_cluster_r[rd_idx] == '0) &&
                     (core_freq_r[rd_idx] < trig_freq_r);
      st_cap_r    <= PROD_W'(core_cap_r[rd_idx]) * PROD_W'(busy_pct_r);
      st_util_x_r <= PROD_W'(core_util_r[rd_idx]) * PROD_W'(PERCENT_SCALE);
      st_util_r   <= core_util_r[rd_idx];
      st_idx_r    <= scan_idx_r;
    end
  end

  // Light-task products, formed while the scan runs
  logic [PROD_W-1:0] lt_util_x_r;
  logic [PROD_W-1:0] lt_util1_x_r;
  logic [PROD_W-1:0] lt_cap80_r;
  logic [PROD_W-1:0] lt_cap_heavy_r;

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      lt_util_x_r    <= PROD_W'(tutil_r) * PROD_W'(PERCENT_SCALE);
      lt_util1_x_r   <= (PROD_W'(tutil_r) + 1'b1) * PROD_W'(PERCENT_SCALE);
      lt_cap80_r     <= PROD_W'(tcap_r) * PROD_W'(LIGHT_CAP_PCT);
      lt_cap_heavy_r <= PROD_W'(tcap_r) * PROD_W'(heavy_pct_r);
    end
  end

  // Evaluate stage: keep the least-utilised qualifying core, lowest index on a tie
  logic              found_r;
  logic [UTIL_W-1:0] low_util_r;
  logic [SCAN_IDX_W-1:0] best_r;
  logic              better;

  assign better = st_valid_r && st_ok_r && (st_cap_r > st_util_x_r) &&
                  (!found_r || (st_util_r < low_util_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.load_task) begin
      found_r <= 1'b0;
    end else if (cmd.eval && better) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && better) begin
      low_util_r <= st_util_r;
      best_r     <= st_idx_r;
    end
  end

  // Result register, shown for one cycle.
  // Light means util*100 <= cap*80 and (util+1)*100 <= cap*heavy, the exact
  // forms of the two floored percentage limits.
  logic                   out_valid_r;
  logic                   out_found_r;
  logic [CPU_INDEX_W-1:0] out_best_r;
  logic                   out_light_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found_r <= found_r;
      out_best_r  <= found_r ? CPU_INDEX_W'(best_r) : '0;
      out_light_r <= (lt_util_x_r <= lt_cap80_r) && (lt_util1_x_r <= lt_cap_heavy_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_chosen_cpu = out_best_r;
  assign out_task_light = out_light_r;

endmodule

### hdl/little_core_placement_selector.sv
// Top level of the little-core placement selector.
// An update request writes one core table entry in the cycle it is taken and
// gives no result; busy stays low, so updates may follow each other every
// cycle. A placement request keeps busy high through one fetch state per
// table entry, one evaluate state and one result state, after which the next
// request can be taken; the scan reads one table entry per cycle through a
// two-stage fetch and compare pipeline. The result appears on the out_ ports
// with out_valid high for exactly one cycle, in the cycle in which busy falls,
// and the receiver cannot stall it. Configuration writes take effect at once
// and must only be made while no placement is in flight.
module little_core_placement_selector import lcps_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_action,
  input  logic [CPU_INDEX_W-1:0] in_cpu_index,
  input  logic [UTIL_W-1:0]      in_cpu_util,
  input  logic [UTIL_W-1:0]      in_cpu_capacity,
  input  logic [FREQ_W-1:0]      in_cpu_freq_khz,
  input  logic [CLUSTER_W-1:0]   in_cpu_cluster,
  input  logic [UTIL_W-1:0]      in_task_util,
  input  logic [UTIL_W-1:0]      in_task_capacity,
  input  logic [MASK_W-1:0]      in_allowed_mask,
  output logic                   out_valid,
  output logic                   out_found,
  output logic [CPU_INDEX_W-1:0] out_chosen_cpu,
  output logic                   out_task_light,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer
  lcps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  // Table, scan and result datapath
  lcps_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_cpu_index     (in_cpu_index),
    .in_cpu_util      (in_cpu_util),
    .in_cpu_capacity  (in_cpu_capacity),
    .in_cpu_freq_khz  (in_cpu_freq_khz),
    .in_cpu_cluster   (in_cpu_cluster),
    .in_task_util     (in_task_util),
    .in_task_capacity (in_task_capacity),
    .in_allowed_mask  (in_allowed_mask),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_chosen_cpu   (out_chosen_cpu),
    .out_task_light   (out_task_light)
  );

endmodule

### hdl/lcps_checker.sv
// Port-level checker for the little-core placement selector and its bind.
module lcps_checker import lcps_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   in_action,
  input logic                   out_valid,
  input logic                   out_found,
  input logic [CPU_INDEX_W-1:0] out_chosen_cpu
);

  // A result is shown in the cycle after the last busy cycle of its request.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe not at the end of a busy period");

  // Each placement gives a single one-cycle strobe.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Busy rises only after a placement request was taken.
  a_busy_from_place: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && (action_t'(in_action) == ACT_PLACE)))
    else $error("busy rose without a placement request");

  // No core found means the reported core is zero.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_chosen_cpu == '0))
    else $error("core index not zero when none was found");

endmodule

bind little_core_placement_selector lcps_checker u_lcps_checker (.*);

### verif/tb.sv
// Self-checking testbench for the little-core placement selector: directed table, then random phases.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lcps_pkg::*;

  localparam int HALF_PERIOD     = 5;
  localparam int RESET_CYCLES    = 4;
  localparam int SETTLE_CYCLES   = 12;
  localparam int IDLE_LIMIT      = 2000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 160;
  localparam int MAX_PRINTS      = 100;

  localparam int unsigned LIGHT_PCT = 80;
  localparam int unsigned PCT_SCALE = 100;

  localparam logic [UTIL_W-1:0]    UTIL_CEIL = 11'd1024;
  localparam logic [FREQ_W-1:0]    FREQ_TOP  = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    action_t                act;
    logic [CPU_INDEX_W-1:0] cpu;
    logic [UTIL_W-1:0]      cpu_util;
    logic [UTIL_W-1:0]      cpu_cap;
    logic [FREQ_W-1:0]      cpu_freq;
    logic [CLUSTER_W-1:0]   cpu_cluster;
    logic [UTIL_W-1:0]      task_util;
    logic [UTIL_W-1:0]      task_cap;
    logic [MASK_W-1:0]      mask;
  } sched_req_t;

  typedef struct {
    logic                   found;
    logic [CPU_INDEX_W-1:0] best;
    logic                   light;
  } placement_t;

  typedef struct {
    sched_req_t req;
    bit         fixed;
    placement_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  logic in_action;
  logic [CPU_INDEX_W-1:0] in_cpu_index;
  logic [UTIL_W-1:0]      in_cpu_util;
  logic [UTIL_W-1:0]      in_cpu_capacity;
  logic [FREQ_W-1:0]      in_cpu_freq_khz;
  logic [CLUSTER_W-1:0]   in_cpu_cluster;
  logic [UTIL_W-1:0]      in_task_util;
  logic [UTIL_W-1:0]      in_task_capacity;
  logic [MASK_W-1:0]      in_allowed_mask;
  logic                   out_valid;
  logic                   out_found;
  logic [CPU_INDEX_W-1:0] out_chosen_cpu;
  logic                   out_task_light;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Local copy of the core table and the settings.
  logic [UTIL_W-1:0]    core_util_tbl    [NUM_CORES];
  logic [UTIL_W-1:0]    core_cap_tbl     [NUM_CORES];
  logic [FREQ_W-1:0]    core_freq_tbl    [NUM_CORES];
  logic [CLUSTER_W-1:0] core_cluster_tbl [NUM_CORES];
  logic [PCT_W-1:0]     heavy_pct;
  logic [PCT_W-1:0]     busy_pct;
  logic [FREQ_W-1:0]    trig_khz;

  placement_t pending_placements[$];
  dir_row_t   dir_tab[$];
  int         mismatch_cnt = 0;
  int         idle_cycles  = 0;

  little_core_placement_selector uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_cpu_index     (in_cpu_index),
    .in_cpu_util      (in_cpu_util),
    .in_cpu_capacity  (in_cpu_capacity),
    .in_cpu_freq_khz  (in_cpu_freq_khz),
    .in_cpu_cluster   (in_cpu_cluster),
    .in_task_util     (in_task_util),
    .in_task_capacity (in_task_capacity),
    .in_allowed_mask  (in_allowed_mask),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_chosen_cpu   (out_chosen_cpu),
    .out_task_light   (out_task_light),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Utilisation and capacity values above 1024 are held at 1024.
  function automatic logic [UTIL_W-1:0] clamp_util(input logic [UTIL_W-1:0] v);
    return (v > UTIL_CEIL) ? UTIL_CEIL : v;
  endfunction

  // Least-utilised qualifying little core, lowest index on a tie, plus the light flag.
  function automatic placement_t pick_little_core(input sched_req_t r);
    placement_t       p;
    logic [UTIL_W-1:0] tu;
    logic [UTIL_W-1:0] tc;
    logic [UTIL_W-1:0] low_util;
    p.found  = 1'b0;
    p.best   = '0;
    low_util = '0;
    tu = clamp_util(r.task_util);
    tc = clamp_util(r.task_cap);
    for (int i = 0; i < NUM_CORES && i < MASK_W; i++) begin
      if (r.mask[i] && core_cluster_tbl[i] == '0 && core_freq_tbl[i] < trig_khz &&
          32'(core_cap_tbl[i]) * 32'(busy_pct) > 32'(core_util_tbl[i]) * PCT_SCALE &&
          (!p.found || core_util_tbl[i] < low_util)) begin
        p.found  = 1'b1;
        low_util = core_util_tbl[i];
        p.best   = CPU_INDEX_W'(i);
      end
    end
    p.light = (32'(tu) <= 32'(tc) * LIGHT_PCT / PCT_SCALE) &&
              (32'(tu) < 32'(tc) * 32'(heavy_pct) / PCT_SCALE);
    return p;
  endfunction

  function automatic logic [UTIL_W-1:0] rand_util();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return UTIL_CEIL;
      2: return UTIL_W'($urandom_range(1025, 2047));
      3: return UTIL_W'($urandom_range(0, 7));
      default: return UTIL_W'($urandom_range(0, 1024));
    endcase
  endfunction

  // Frequencies cluster around the current trigger so both sides of it are hit.
  function automatic logic [FREQ_W-1:0] rand_freq();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return FREQ_TOP;
      2: return trig_khz - 1'b1;
      3: return trig_khz;
      default: return FREQ_W'($urandom);
    endcase
  endfunction

  function automatic sched_req_t rand_request();
    sched_req_t r;
    r.act         = ($urandom_range(0, 9) < 4) ? ACT_UPDATE : ACT_PLACE;
    r.cpu         = CPU_INDEX_W'($urandom);
    r.cpu_util    = rand_util();
    r.cpu_cap     = rand_util();
    r.cpu_freq    = rand_freq();
    r.cpu_cluster = ($urandom_range(0, 9) < 7) ? '0 : CLUSTER_W'($urandom);
    r.task_util   = rand_util();
    r.task_cap    = rand_util();
    r.mask        = ($urandom_range(0, 3) == 0) ? '1 : MASK_W'($urandom);
    return r;
  endfunction

  // Directed requests keep random values in the fields their action ignores.
  function automatic sched_req_t mk_update(input logic [CPU_INDEX_W-1:0] cpu,
                                           input logic [UTIL_W-1:0] u, c,
                                           input logic [FREQ_W-1:0] f,
                                           input logic [CLUSTER_W-1:0] cl);
    sched_req_t r;
    r             = rand_request();
    r.act         = ACT_UPDATE;
    r.cpu         = cpu;
    r.cpu_util    = u;
    r.cpu_cap     = c;
    r.cpu_freq    = f;
    r.cpu_cluster = cl;
    return r;
  endfunction

  function automatic sched_req_t mk_place(input logic [UTIL_W-1:0] tu, tc,
                                          input logic [MASK_W-1:0] m);
    sched_req_t r;
    r           = rand_request();
    r.act       = ACT_PLACE;
    r.task_util = tu;
    r.task_cap  = tc;
    r.mask      = m;
    return r;
  endfunction

  function automatic void add_row(input sched_req_t r, input bit fixed = 1'b0,
                                  input logic f = 1'b0,
                                  input logic [CPU_INDEX_W-1:0] b = '0,
                                  input logic l = 1'b0);
    dir_row_t row;
    row.req        = r;
    row.fixed      = fixed;
    row.want.found = f;
    row.want.best  = b;
    row.want.light = l;
    dir_tab.push_back(row);
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatch_cnt < MAX_PRINTS) $display("[%0t] placement mismatch: %s", $time, what);
    mismatch_cnt++;
  endtask

  // Present one request and hold it until it is taken, then update the local model.
  task automatic send_request(input sched_req_t r, input bit fixed, input placement_t want);
    start            <= 1'b1;
    in_action        <= r.act;
    in_cpu_index     <= r.cpu;
    in_cpu_util      <= r.cpu_util;
    in_cpu_capacity  <= r.cpu_cap;
    in_cpu_freq_khz  <= r.cpu_freq;
    in_cpu_cluster   <= r.cpu_cluster;
    in_task_util     <= r.task_util;
    in_task_capacity <= r.task_cap;
    in_allowed_mask  <= r.mask;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (r.act == ACT_UPDATE) begin
      if (int'(r.cpu) < NUM_CORES) begin
        core_util_tbl[r.cpu]    = clamp_util(r.cpu_util);
        core_cap_tbl[r.cpu]     = clamp_util(r.cpu_cap);
        core_freq_tbl[r.cpu]    = r.cpu_freq;
        core_cluster_tbl[r.cpu] = r.cpu_cluster;
      end
    end else begin
      pending_placements.push_back(fixed ? want : pick_little_core(r));
    end
  endtask

  // Random gaps between requests; every fourth run of sixteen goes back to back.
  task automatic pause_sender(input int n);
    int g;
    if ((n / 16) % 4 == 3) begin
      g = 0;
    end else begin
      case ($urandom_range(0, 19))
        0: g = $urandom_range(10, 40);
        1, 2, 3, 4, 5, 6: g = $urandom_range(1, 3);
        default: g = 0;
      endcase
    end
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Stop sending and let every placement in flight come out.
  task automatic wait_for_quiet();
    start <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    logic [CFG_DATA_W-1:0] word;
    word = val;
    // Bits above a percent register carry noise that the block must drop.
    if (idx == CFG_HEAVY_PCT || idx == CFG_BUSY_PCT)
      word[CFG_DATA_W-1:PCT_W] = (CFG_DATA_W-PCT_W)'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    case (idx)
      CFG_HEAVY_PCT: heavy_pct = word[PCT_W-1:0];
      CFG_BUSY_PCT:  busy_pct  = word[PCT_W-1:0];
      CFG_TRIG_FREQ: trig_khz  = word[FREQ_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // The first three phases take the extremes of the settings, the rest random ones.
  task automatic program_phase(input int ph);
    logic [PCT_W-1:0]  hv;
    logic [PCT_W-1:0]  bz;
    logic [FREQ_W-1:0] tf;
    case (ph)
      0: begin
        hv = '0;
        bz = '1;
        tf = FREQ_TOP;
      end
      1: begin
        hv = '1;
        bz = '0;
        tf = FREQ_TOP;
      end
      2: begin
        hv = 7'd100;
        bz = 7'd100;
        tf = '0;
      end
      default: begin
        hv = PCT_W'($urandom_range(0, 127));
        bz = PCT_W'($urandom_range(40, 127));
        tf = ($urandom_range(0, 1) == 1) ? FREQ_W'($urandom)
                                         : FREQ_W'($urandom_range(300000, 3000000));
      end
    endcase
    write_reg(CFG_HEAVY_PCT, CFG_DATA_W'(hv));
    write_reg(CFG_BUSY_PCT, CFG_DATA_W'(bz));
    write_reg(CFG_TRIG_FREQ, tf);
    // An index with no register behind it must leave every setting alone.
    if (ph == 0) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
  endtask

  // Compare each result with the oldest outstanding placement.
  always @(posedge clk) begin
    placement_t exp_p;
    if (rst_n && out_valid) begin
      if (pending_placements.size() == 0) begin
        flag_mismatch("result with no placement request outstanding");
      end else begin
        exp_p = pending_placements.pop_front();
        if (out_found !== exp_p.found)
          flag_mismatch($sformatf("found got %b, expected %b", out_found, exp_p.found));
        if (out_chosen_cpu !== exp_p.best)
          flag_mismatch($sformatf("chosen_cpu got %0d, expected %0d",
                                  out_chosen_cpu, exp_p.best));
        if (out_task_light !== exp_p.light)
          flag_mismatch($sformatf("task_light got %b, expected %b",
                                  out_task_light, exp_p.light));
      end
    end
  end

  // Watchdog on cycles where nothing moves on either side.
  always @(posedge clk) begin
    if (!rst_n || out_valid || cfg_we || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    placement_t blank;
    blank.found = 1'b0;
    blank.best  = '0;
    blank.light = 1'b0;

    // Table and settings as they come out of reset.
    for (int i = 0; i < NUM_CORES; i++) begin
      core_util_tbl[i]    = '0;
      core_cap_tbl[i]     = '0;
      core_freq_tbl[i]    = '0;
      core_cluster_tbl[i] = '0;
    end
    heavy_pct = HEAVY_PCT_RST;
    busy_pct  = BUSY_PCT_RST;
    trig_khz  = TRIG_FREQ_RST;

    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_action        <= ACT_UPDATE;
    in_cpu_index     <= '0;
    in_cpu_util      <= '0;
    in_cpu_capacity  <= '0;
    in_cpu_freq_khz  <= '0;
    in_cpu_cluster   <= '0;
    in_task_util     <= '0;
    in_task_capacity <= '0;
    in_allowed_mask  <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_HEAVY_PCT;
    cfg_data         <= '0;

    // A cleared table has no core that passes the busy test; a zero-capacity task is heavy.
    add_row(mk_place(11'd0, 11'd0, 8'hFF), 1'b1, 1'b0, 3'd0, 1'b0);
    // Saturated task values with an empty mask.
    add_row(mk_place(11'd2047, 11'd2047, 8'h00), 1'b1, 1'b0, 3'd0, 1'b0);
    // A single idle little core with a saturated capacity is the only candidate.
    add_row(mk_update(3'd3, 11'd0, 11'd2047, 22'd0, 4'd0));
    add_row(mk_place(11'd100, 11'd1024, 8'hFF), 1'b1, 1'b1, 3'd3, 1'b1);
    // Equal utilisation on cores 3 and 5: the lower index must win.
    add_row(mk_update(3'd5, 11'd0, 11'd1024, 22'd1502999, 4'd0));
    add_row(mk_place(11'd1024, 11'd1024, 8'hFF));
    add_row(mk_place(11'd0, 11'd1024, 8'h20));
    // Cores knocked out by busy load, by frequency at the trigger and by cluster.
    add_row(mk_update(3'd0, 11'd2047, 11'd1024, 22'd0, 4'd0));
    add_row(mk_update(3'd7, 11'd10, 11'd1024, 22'd1503000, 4'd0));
    add_row(mk_update(3'd6, 11'd5, 11'd1024, FREQ_TOP, 4'hF));
    add_row(mk_update(3'd1, 11'd1, 11'd1024, 22'd0, 4'd1));
    add_row(mk_place(11'd819, 11'd1024, 8'hFF));
    // Busy test just failing and just passing.
    add_row(mk_update(3'd3, 11'd900, 11'd1024, 22'd0, 4'd0));
    add_row(mk_update(3'd2, 11'd1024, 11'd1024, 22'd0, 4'd0));
    add_row(mk_update(3'd4, 11'd869, 11'd1024, 22'd0, 4'd0));
    // Light limits either side of half capacity.
    add_row(mk_place(11'd511, 11'd1024, 8'hDF));
    add_row(mk_place(11'd512, 11'd1024, 8'h10));
    add_row(mk_place(11'd1025, 11'd1030, 8'hFF));
    add_row(mk_update(3'd5, 11'd2047, 11'd2047, 22'd0, 4'd0));
    add_row(mk_place(11'd0, 11'd1024, 8'hFF));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[k]) begin
      send_request(dir_tab[k].req, dir_tab[k].fixed, dir_tab[k].want);
      pause_sender(k);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_for_quiet();
      program_phase(ph);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_request(rand_request(), 1'b0, blank);
        pause_sender(n);
      end
    end

    wait_for_quiet();
    if (mismatch_cnt == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

### filelist.f
hdl/lcps_pkg.sv
hdl/lcps_ctrl.sv
hdl/lcps_dp.sv
hdl/little_core_placement_selector.sv
hdl/lcps_checker.sv
verif/tb.sv
